// ===== hdl/bedd_pkg.sv =====
// Shared constants and types for the binary error-diffusion dither.
// No dependencies; used by every module of the block except the line store.
`timescale 1ns / 1ps

package bedd_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int MAX_WIDTH_DEFAULT  = 4096;
  localparam int ERROR_BITS_DEFAULT = 12;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int WIDTH_BITS     = 13;
  localparam int HEIGHT_BITS    = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
  localparam int                     MIN_WIDTH    = 2;

  // Pixel levels.
  localparam int PIXEL_BITS = 8;
  localparam int THRESHOLD  = 128;
  localparam int LEVEL_MAX  = 255;

  // Per-pixel raster position flags.
  typedef struct packed {
    logic first_row;
    logic end_row;
    logic end_frame;
  } pos_t;

endpackage

// ===== hdl/bedd_line_store.sv =====
// Line store holding the accumulated error for each column of the next row.
// One write port, one registered read port with write-to-read forwarding.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module bedd_line_store #(
  parameter int DEPTH = 4096,
  parameter int DATA_BITS = 12,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_BITS-1:0]        wr_addr,
  input  logic signed [DATA_BITS-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_BITS-1:0]        rd_addr,
  output logic signed [DATA_BITS-1:0] rd_data
);

  logic signed [DATA_BITS-1:0] mem [DEPTH];
  logic signed [DATA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // forward a same-cycle write so the read sees the newest value
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/bedd_position.sv =====
// Raster position tracker: column and row counters for accepted pixels.
// Uses bedd_pkg for the position flag struct and register widths.
`timescale 1ns / 1ps

module bedd_position #(
  parameter int MAX_WIDTH = bedd_pkg::MAX_WIDTH_DEFAULT,
  localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic [bedd_pkg::WIDTH_BITS-1:0]    image_width,
  input  logic [bedd_pkg::HEIGHT_BITS-1:0]   image_height,
  output logic [COL_BITS-1:0]                col,
  output bedd_pkg::pos_t                     pos
);

  localparam int LW = 15;
  localparam int HW = bedd_pkg::HEIGHT_BITS + 1;

  logic [COL_BITS-1:0]              col_r, col_nxt;
  logic [bedd_pkg::HEIGHT_BITS-1:0] row_r, row_nxt;
  logic [LW-1:0]                    w_eff;
  logic [HW-1:0]                    h_eff;

  always_comb begin
    if (LW'(image_width) < LW'(bedd_pkg::MIN_WIDTH)) begin
      w_eff = LW'(bedd_pkg::MIN_WIDTH);
    end else if (LW'(image_width) > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = LW'(image_width);
    end
    h_eff = (image_height == '0) ? HW'(1) : HW'(image_height);

    pos.first_row = (row_r == '0);
    pos.end_row   = (LW'(col_r) + LW'(1)) >= w_eff;
    pos.end_frame = pos.end_row && ((HW'(row_r) + HW'(1)) >= h_eff);

    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (pos.end_row) begin
        col_nxt = '0;
        row_nxt = pos.end_frame ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;

endmodule

// ===== hdl/bedd_diffuse.sv =====
// Threshold and Floyd-Steinberg error spreading for one pixel per cycle while advance is high.
// Holds the right carry and the two partial sums for the next row, and
// drives the line-store writes. Uses bedd_pkg for pixel constants and flags.
`timescale 1ns / 1ps

module bedd_diffuse #(
  parameter int MAX_WIDTH = bedd_pkg::MAX_WIDTH_DEFAULT,
  parameter int ERROR_BITS = bedd_pkg::ERROR_BITS_DEFAULT,
  localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic [bedd_pkg::PIXEL_BITS-1:0]     gray,
  input  logic signed [ERROR_BITS-1:0]        acc,
  input  logic [COL_BITS-1:0]                 col,
  input  bedd_pkg::pos_t                      pos,
  output logic [bedd_pkg::PIXEL_BITS-1:0]     level,
  output logic                                wr_en,
  output logic [COL_BITS-1:0]                 wr_addr,
  output logic signed [ERROR_BITS-1:0]        wr_data
);

  localparam int SW = ERROR_BITS + 6;
  localparam logic signed [SW-1:0] ERR_HI = SW'((1 << (ERROR_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] ERR_LO = -ERR_HI - SW'(1);
  localparam logic signed [SW-1:0] THRESH = SW'(bedd_pkg::THRESHOLD);
  localparam logic signed [SW-1:0] LVL_HI = SW'(bedd_pkg::LEVEL_MAX);

  function automatic logic signed [ERROR_BITS-1:0] sat_err(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = v;
    if (v > ERR_HI) begin
      c = ERR_HI;
    end else if (v < ERR_LO) begin
      c = ERR_LO;
    end
    return c[ERROR_BITS-1:0];
  endfunction

  logic signed [ERROR_BITS-1:0] right_carry_r, right_carry_nxt;
  logic signed [ERROR_BITS-1:0] below_r, below_nxt;
  logic signed [ERROR_BITS-1:0] below_right_r, below_right_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic [COL_BITS-1:0]          pend_addr_r;
  logic signed [ERROR_BITS-1:0] pend_data_r;

  logic signed [SW-1:0]         sum, err, t7, t3, t5, t1;
  logic                         hi;
  logic signed [ERROR_BITS-1:0] below_left_val, below_val, below_right_val;

  always_comb begin
    sum = SW'($signed({1'b0, gray})) + SW'(acc) + SW'(right_carry_r);
    hi  = (sum >= THRESH);
    err = hi ? (sum - LVL_HI) : sum;
    // weights 7, 3, 5, 1 as shift-and-add, each floored by 16
    t7 = ((err <<< 3) - err) >>> 4;
    t3 = ((err <<< 1) + err) >>> 4;
    t5 = ((err <<< 2) + err) >>> 4;
    t1 = err >>> 4;

    below_left_val  = sat_err(SW'(below_r) + t3);
    below_val       = sat_err(SW'(below_right_r) + t5);
    below_right_val = sat_err(t1);

    level = hi ? bedd_pkg::PIXEL_BITS'(bedd_pkg::LEVEL_MAX) : '0;

    right_carry_nxt = right_carry_r;
    below_nxt       = below_r;
    below_right_nxt = below_right_r;
    pend_v_nxt      = 1'b0;
    if (advance) begin
      if (pos.end_row) begin
        // clear the row carries; the last column's write goes next cycle
        right_carry_nxt = '0;
        below_nxt       = '0;
        below_right_nxt = '0;
        pend_v_nxt      = 1'b1;
      end else begin
        right_carry_nxt = sat_err(t7);
        below_nxt       = below_val;
        below_right_nxt = below_right_val;
      end
    end

    // the pixel after a row end is column zero and never writes
    if (pend_v_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_r;
      wr_data = pend_data_r;
    end else begin
      wr_en   = advance && (col != '0);
      wr_addr = col - COL_BITS'(1);
      wr_data = below_left_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_carry_r <= '0;
      below_r       <= '0;
      below_right_r <= '0;
      pend_v_r      <= 1'b0;
    end else begin
      right_carry_r <= right_carry_nxt;
      below_r       <= below_nxt;
      below_right_r <= below_right_nxt;
      pend_v_r      <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pos.end_row) begin
      pend_addr_r <= col;
      pend_data_r <= below_val;
    end
  end

endmodule

// ===== hdl/binary_error_diffusion_dither.sv =====
// Binary error-diffusion dither: 8-bit gray pixels in, 0 or 255 out.
// Pixels enter in raster order on in_valid/in_ready; each gets the error
// diffused into it from its left neighbor and from the row above, is
// thresholded at 128, and leaves on out_valid/out_ready with row_last and
// frame_last flags marking the end of a row and of the frame.
// One pixel is taken per clock while the output is not stalled; a pixel
// passes through the input register, then the result register. The error
// feedback to the next pixel is one combinational adder chain, and the row
// above comes from a line store read at transfer time.
// A stalled receiver holds the result register; the input side keeps taking
// pixels until the input register is also full, then drops in_ready.
// cfg_valid/cfg_ready writes image_width (index 0) and image_height
// (index 1); cfg_ready is always high. Write them only while no pixel is in
// flight. Synchronous reset restores 640 by 480, clears the position
// counters and carries and empties both stages; the line store needs no
// clearing because the first row of each frame ignores its read data.
`timescale 1ns / 1ps

module binary_error_diffusion_dither #(
  parameter int MAX_WIDTH = bedd_pkg::MAX_WIDTH_DEFAULT,
  parameter int ERROR_BITS = bedd_pkg::ERROR_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [bedd_pkg::PIXEL_BITS-1:0]       in_gray_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bedd_pkg::PIXEL_BITS-1:0]       out_level_out,
  output logic                                  out_row_last,
  output logic                                  out_frame_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bedd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bedd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [bedd_pkg::WIDTH_BITS-1:0]  image_width_r;
  logic [bedd_pkg::HEIGHT_BITS-1:0] image_height_r;

  logic                             s1_v_r;
  logic [bedd_pkg::PIXEL_BITS-1:0]  s1_gray_r;
  logic [COL_BITS-1:0]              s1_col_r;
  bedd_pkg::pos_t                   s1_pos_r;

  logic                             out_v_r;
  logic [bedd_pkg::PIXEL_BITS-1:0]  out_level_r;
  logic                             out_row_last_r;
  logic                             out_frame_last_r;

  logic                             accept, s1_adv;
  logic [COL_BITS-1:0]              cur_col;
  bedd_pkg::pos_t                   cur_pos;
  logic signed [ERROR_BITS-1:0]     rd_data, acc;
  logic [bedd_pkg::PIXEL_BITS-1:0]  level;
  logic                             wr_en;
  logic [COL_BITS-1:0]              wr_addr;
  logic signed [ERROR_BITS-1:0]     wr_data;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= bedd_pkg::WIDTH_RESET;
      image_height_r <= bedd_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bedd_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[bedd_pkg::WIDTH_BITS-1:0];
        bedd_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[bedd_pkg::HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  bedd_position #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_position (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .col          (cur_col),
    .pos          (cur_pos)
  );

  bedd_line_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (ERROR_BITS)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (cur_col),
    .rd_data (rd_data)
  );

  // first row of a frame ignores the store
  assign acc = s1_pos_r.first_row ? '0 : rd_data;

  bedd_diffuse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .ERROR_BITS (ERROR_BITS)
  ) u_diffuse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .gray    (s1_gray_r),
    .acc     (acc),
    .col     (s1_col_r),
    .pos     (s1_pos_r),
    .level   (level),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gray_r <= in_gray_in;
      s1_col_r  <= cur_col;
      s1_pos_r  <= cur_pos;
    end
    if (s1_adv) begin
      out_level_r      <= level;
      out_row_last_r   <= s1_pos_r.end_row;
      out_frame_last_r <= s1_pos_r.end_frame;
    end
  end

  assign out_valid      = out_v_r;
  assign out_level_out  = out_level_r;
  assign out_row_last   = out_row_last_r;
  assign out_frame_last = out_frame_last_r;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for binary_error_diffusion_dither: streams gray pixels under
// several image geometries and handshake pressures, predicts every dithered pixel
// with its row/frame flags and compares them. Depends on bedd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_DEPTH   = bedd_pkg::MAX_WIDTH_DEFAULT;
  localparam int ERR_BITS      = bedd_pkg::ERROR_BITS_DEFAULT;
  localparam int ERR_MAX       = (1 << (ERR_BITS - 1)) - 1;
  localparam int ERR_MIN       = -ERR_MAX - 1;
  localparam int PIX_BITS      = bedd_pkg::PIXEL_BITS;
  localparam int PIX_MAX       = bedd_pkg::LEVEL_MAX;
  localparam int IDX_BITS      = bedd_pkg::CFG_INDEX_BITS;
  localparam int CFG_DW        = bedd_pkg::CFG_DATA_BITS;
  localparam int SPARE_BITS    = CFG_DW - bedd_pkg::WIDTH_BITS;
  localparam int RANDOM_PIXELS = 1850;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 300;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [PIX_BITS-1:0] level;
    logic                row_last;
    logic                frame_last;
  } dither_pixel_t;

  typedef enum int {GRAY_UNIFORM, GRAY_FLAT, GRAY_EXTREME, GRAY_RAMP} gray_style_t;

  class dither_scoreboard;
    logic [bedd_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [bedd_pkg::HEIGHT_BITS-1:0] height_reg;
    logic signed [ERR_BITS-1:0] line_err [STORE_DEPTH];
    logic signed [ERR_BITS-1:0] carry_right;
    logic signed [ERR_BITS-1:0] below_acc;
    logic signed [ERR_BITS-1:0] below_right_acc;
    int unsigned                col;
    int unsigned                row;
    int unsigned                store_span;
    dither_pixel_t              expected_q[$];
    int                         failures;

    function new();
      width_reg       = bedd_pkg::WIDTH_RESET;
      height_reg      = bedd_pkg::HEIGHT_RESET;
      carry_right     = '0;
      below_acc       = '0;
      below_right_acc = '0;
      col             = 0;
      row             = 0;
      store_span      = 0;
      failures        = 0;
    endfunction

    function int unsigned width_for(logic [bedd_pkg::WIDTH_BITS-1:0] w);
      if (int'(w) < bedd_pkg::MIN_WIDTH) return bedd_pkg::MIN_WIDTH;
      if (int'(w) > STORE_DEPTH) return STORE_DEPTH;
      return int'(w);
    endfunction

    function logic signed [ERR_BITS-1:0] clip(int v);
      if (v > ERR_MAX) v = ERR_MAX;
      else if (v < ERR_MIN) v = ERR_MIN;
      return ERR_BITS'(v);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
    endfunction

    function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_DW-1:0] data);
      if (idx == bedd_pkg::REG_IMAGE_WIDTH) width_reg = data[bedd_pkg::WIDTH_BITS-1:0];
      else if (idx == bedd_pkg::REG_IMAGE_HEIGHT)
        height_reg = data[bedd_pkg::HEIGHT_BITS-1:0];
    endfunction

    // Columns are always written in order from zero, so the written part is a prefix.
    function void store_err(int unsigned idx, logic signed [ERR_BITS-1:0] v);
      line_err[idx] = v;
      if (idx + 1 > store_span) store_span = idx + 1;
    endfunction

    function void note_pixel(logic [PIX_BITS-1:0] gray);
      int            gathered;
      int            total;
      int            err;
      int unsigned   rows;
      dither_pixel_t res;
      gathered  = (row != 0) ? int'(line_err[col]) : 0;
      total     = int'(gray) + gathered + int'(carry_right);
      res.level = (total < bedd_pkg::THRESHOLD) ? '0 : PIX_BITS'(PIX_MAX);
      err       = total - ((total < bedd_pkg::THRESHOLD) ? 0 : PIX_MAX);
      carry_right = clip((7 * err) >>> 4);
      if (col > 0) store_err(col - 1, clip(int'(below_acc) + ((3 * err) >>> 4)));
      below_acc       = clip(int'(below_right_acc) + ((5 * err) >>> 4));
      below_right_acc = clip(err >>> 4);
      res.row_last    = (col + 1 >= width_for(width_reg));
      res.frame_last  = 1'b0;
      if (res.row_last) begin
        store_err(col, below_acc);
        carry_right     = '0;
        below_acc       = '0;
        below_right_acc = '0;
        col             = 0;
        rows = (height_reg == '0) ? 1 : int'(height_reg);
        res.frame_last  = (row + 1 >= rows);
        row = res.frame_last ? 0 : row + 1;
      end else begin
        col++;
      end
      expected_q.push_back(res);
    endfunction

    function void check_pixel(dither_pixel_t got);
      dither_pixel_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected pixel: level=%0d row_last=%0b frame_last=%0b",
                         got.level, got.row_last, got.frame_last));
        return;
      end
      want = expected_q.pop_front();
      if (got != want)
        report($sformatf({"pixel mismatch: expected level=%0d row_last=%0b frame_last=%0b,",
                          " got level=%0d row_last=%0b frame_last=%0b"},
                         want.level, want.row_last, want.frame_last,
                         got.level, got.row_last, got.frame_last));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_BITS-1:0]   in_gray_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_BITS-1:0]   out_level_out;
  logic                  out_row_last;
  logic                  out_frame_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [IDX_BITS-1:0]   cfg_index;
  logic [CFG_DW-1:0]     cfg_data;

  dither_scoreboard sb;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_requests   = 0;
  int quiet_cycles    = 0;

  binary_error_diffusion_dither u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_gray_in     (in_gray_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level_out  (out_level_out),
    .out_row_last   (out_row_last),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample every transfer on the pre-edge values.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    if (rst_n && in_valid && in_ready) sb.note_pixel(in_gray_in);
    if (rst_n && out_valid && out_ready)
      sb.check_pixel(dither_pixel_t'({out_level_out, out_row_last, out_frame_last}));
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Tasks enter and leave just after a falling edge.
  task automatic write_cfg(logic [IDX_BITS-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [PIX_BITS-1:0] gray);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_gray_in <= gray;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold the input until every predicted pixel has come out, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [PIX_BITS-1:0] pick_gray(gray_style_t style, int idx, int base);
    int v;
    case (style)
      GRAY_FLAT: v = base + int'($urandom_range(6)) - 3;
      GRAY_EXTREME: begin
        case ($urandom_range(3))
          0:       v = 0;
          1:       v = PIX_MAX;
          2:       v = bedd_pkg::THRESHOLD - 1;
          default: v = bedd_pkg::THRESHOLD;
        endcase
      end
      GRAY_RAMP: v = (base + idx * 4) % (PIX_MAX + 1);
      default:   v = int'($urandom_range(PIX_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > PIX_MAX) v = PIX_MAX;
    return PIX_BITS'(v);
  endfunction

  initial begin
    logic [PIX_BITS-1:0] seq[$];
    logic [CFG_DW-1:0]   data;
    gray_style_t         style;
    int                  phase;
    int                  n_items;
    int                  base;
    int                  r;
    int                  random_sent;
    sb = new();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_gray_in <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset geometry first, then a width below the minimum lands past the row end.
    seq = '{8'd255, 8'd0};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();
    write_cfg(bedd_pkg::REG_IMAGE_WIDTH, 16'd0);
    write_cfg(bedd_pkg::REG_IMAGE_HEIGHT, 16'd0);
    seq = '{8'd128, 8'd127, 8'd0, 8'd255};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();
    write_cfg(bedd_pkg::REG_IMAGE_WIDTH, 16'd1);
    write_cfg(bedd_pkg::REG_IMAGE_HEIGHT, 16'd3);
    seq = '{8'd255, 8'd0, 8'd1, 8'd254, 8'd128, 8'd127};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();
    write_cfg(bedd_pkg::REG_IMAGE_WIDTH, 16'd3);
    write_cfg(bedd_pkg::REG_IMAGE_HEIGHT, 16'd2);
    seq = '{8'd200, 8'd50, 8'd128, 8'd0, 8'd255, 8'd90};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();
    // Oversized width acts as the store depth; then shrink it mid-row.
    write_cfg(bedd_pkg::REG_IMAGE_WIDTH, 16'd8191);
    write_cfg(bedd_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
    seq = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd128};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();
    write_cfg(bedd_pkg::REG_IMAGE_WIDTH, 16'd2);
    seq = '{8'd64, 8'd192};
    foreach (seq[i]) send_pixel(seq[i]);
    drain();

    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      case (phase % 4)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 53; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin sender_idle_pct = 19; recv_stall_pct = 19; end
      endcase

      if ($urandom_range(99) < 70) begin
        r = $urandom_range(99);
        if (r < 8) data = CFG_DW'($urandom_range(1));
        else if (r < 11) data = CFG_DW'(STORE_DEPTH);
        else if (r < 14) data = CFG_DW'($urandom_range(STORE_DEPTH + 1, 8191));
        else if (r < 25) data = CFG_DW'($urandom_range(13, 300));
        else data = CFG_DW'($urandom_range(2, 12));
        if ($urandom_range(9) == 0)
          data[CFG_DW-1:bedd_pkg::WIDTH_BITS] =
            SPARE_BITS'($urandom_range(1, (1 << SPARE_BITS) - 1));
        // Past the first row the store is read over the new width: keep to written columns.
        if (sb.row != 0 && sb.width_for(data[bedd_pkg::WIDTH_BITS-1:0]) > sb.store_span)
          data = CFG_DW'(sb.store_span);
        write_cfg(bedd_pkg::REG_IMAGE_WIDTH, data);
      end
      if ($urandom_range(99) < 60) begin
        r = $urandom_range(99);
        if (r < 8) data = '0;
        else if (r < 12) data = '1;
        else if (r < 16) data = CFG_DW'($urandom);
        else data = CFG_DW'($urandom_range(1, 6));
        write_cfg(bedd_pkg::REG_IMAGE_HEIGHT, data);
      end
      if ($urandom_range(9) == 0)
        write_cfg(IDX_BITS'($urandom_range(2, (1 << IDX_BITS) - 1)), CFG_DW'($urandom));

      n_items = (sb.width_for(sb.width_reg) > 300) ? $urandom_range(5, 40)
                                                    : $urandom_range(10, 120);
      // Starve the output long enough for the input side to back up.
      if (phase == 2 || $urandom_range(11) == 0) begin
        if (n_items < 40) n_items = 40;
        hold_requests++;
      end
      style = gray_style_t'($urandom_range(3));
      base  = $urandom_range(PIX_MAX);
      for (int i = 0; i < n_items; i++) send_pixel(pick_gray(style, i, base));
      random_sent += n_items;
      drain();
      phase++;
    end

    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d predicted pixels never came out", sb.expected_q.size()));
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
